// ===== design/anp_pkg.sv =====
`timescale 1ns / 1ps

package anp_pkg;

	localparam int unsigned BASE_BITS   = 6;
	localparam int unsigned CHAR_BITS   = 8;
	localparam int unsigned VALUE_BITS  = 32;
	localparam int unsigned OFFSET_BITS = 16;

	localparam logic [BASE_BITS-1:0] MAX_BASE  = 6'd36;
	localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_BITS-1:0] BASE_ONE  = 6'd1;
	localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_BITS-1:0] NO_DIGIT  = 6'd63;

	localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_BITS-1:0] CH_UP_X   = 8'h58;
	localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
	localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_LO_X   = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_LEAD,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_BASE,
		ST_RANGE
	} status_t;

	typedef struct packed {
		phase_t                phase;
		logic                  negative;
		logic                  digit_seen;
		logic [BASE_BITS-1:0]  base;
	} ctl_t;

	function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
		logic [CHAR_BITS-1:0] d;
		d = {2'b00, NO_DIGIT};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = c - CH_LO_A + 8'd10;
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = c - CH_UP_A + 8'd10;
		end
		return d[BASE_BITS-1:0];
	endfunction

endpackage

// ===== design/ascii_unsigned_number_parser.sv =====
`timescale 1ns / 1ps

// ASCII unsigned number parser.
// Input channel: one character per word with first_char marking the start of a
// string; in_valid/in_ready handshake. A string yields at most one result word
// on the output channel (out_valid/out_ready): the value, the count of
// characters consumed up to the end of the number and a status.
// number_base is written through number_base_we and sampled on each first
// character; write it only while the block is idle.
// A result passes through the input register and then the result register
// after the character that ends the number is accepted.
// One character per cycle while no result is held waiting for the receiver;
// the multiply-add of the accumulator by the base sits between those two registers.
// When the receiver stalls with a result pending, the character stage holds
// and in_ready drops once that stage is full; nothing is lost.
// Reset clears the character stage, the result valid flag (not the result data),
// the parse state and number_base; the block then ignores characters until one flagged first_char arrives.

module ascii_unsigned_number_parser #(
	parameter int unsigned VALUE_BITS  = anp_pkg::VALUE_BITS,
	parameter int unsigned OFFSET_BITS = anp_pkg::OFFSET_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           number_base_we,
	input  logic [anp_pkg::BASE_BITS-1:0]  number_base,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [anp_pkg::CHAR_BITS-1:0]  character,
	input  logic                           first_char,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [VALUE_BITS-1:0]          number_value,
	output logic [OFFSET_BITS-1:0]         end_offset,
	output logic [1:0]                     status
);

	logic [anp_pkg::BASE_BITS-1:0] number_base_q;
	logic                          valid_s1;
	logic [anp_pkg::CHAR_BITS-1:0] char_s1;
	logic                          first_s1;
	anp_pkg::ctl_t                 ctl_q;
	anp_pkg::ctl_t                 ctl_nxt;
	logic [VALUE_BITS-1:0]         acc_q;
	logic [VALUE_BITS-1:0]         acc_nxt;
	logic [OFFSET_BITS-1:0]        pos_q;
	logic [OFFSET_BITS-1:0]        pos_nxt;
	logic                          emit;
	logic [VALUE_BITS-1:0]         res_value;
	logic [OFFSET_BITS-1:0]        res_offset;
	anp_pkg::status_t              res_status;
	logic                          out_valid_q;
	logic [VALUE_BITS-1:0]         value_q;
	logic [OFFSET_BITS-1:0]        offset_q;
	anp_pkg::status_t              status_q;
	logic                          advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
		end else if (number_base_we) begin
			number_base_q <= number_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
			first_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				char_s1  <= character;
				first_s1 <= first_char;
			end
		end
	end

	anp_step #(
		.VALUE_BITS  (VALUE_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_step (
		.ctl        (ctl_q),
		.acc        (acc_q),
		.pos        (pos_q),
		.character  (char_s1),
		.first_char (first_s1),
		.cfg_base   (number_base_q),
		.ctl_nxt    (ctl_nxt),
		.acc_nxt    (acc_nxt),
		.pos_nxt    (pos_nxt),
		.emit       (emit),
		.res_value  (res_value),
		.res_offset (res_offset),
		.res_status (res_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= '{phase: anp_pkg::PH_DONE, negative: 1'b0, digit_seen: 1'b0,
			                 base: anp_pkg::BASE_AUTO};
			acc_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				ctl_q <= ctl_nxt;
				acc_q <= acc_nxt;
				pos_q <= pos_nxt;
			end
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			value_q  <= res_value;
			offset_q <= res_offset;
			status_q <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign number_value = value_q;
	assign end_offset   = offset_q;
	assign status       = status_q;

endmodule

// ===== design/anp_step.sv =====
`timescale 1ns / 1ps

module anp_step #(
	parameter int unsigned VALUE_BITS  = anp_pkg::VALUE_BITS,
	parameter int unsigned OFFSET_BITS = anp_pkg::OFFSET_BITS
) (
	input  anp_pkg::ctl_t                  ctl,
	input  logic [VALUE_BITS-1:0]          acc,
	input  logic [OFFSET_BITS-1:0]         pos,
	input  logic [anp_pkg::CHAR_BITS-1:0]  character,
	input  logic                           first_char,
	input  logic [anp_pkg::BASE_BITS-1:0]  cfg_base,
	output anp_pkg::ctl_t                  ctl_nxt,
	output logic [VALUE_BITS-1:0]          acc_nxt,
	output logic [OFFSET_BITS-1:0]         pos_nxt,
	output logic                           emit,
	output logic [VALUE_BITS-1:0]          res_value,
	output logic [OFFSET_BITS-1:0]         res_offset,
	output anp_pkg::status_t               res_status
);

	logic [anp_pkg::BASE_BITS-1:0] dig;
	logic                          consume;
	logic [VALUE_BITS-1:0]         acc_w;
	logic [OFFSET_BITS-1:0]        pos_w;
	logic [VALUE_BITS+anp_pkg::BASE_BITS-1:0] mac;

	assign dig = anp_pkg::digit_of(character);

	always_comb begin
		ctl_nxt    = ctl;
		acc_w      = acc;
		pos_w      = pos;
		consume    = 1'b0;
		emit       = 1'b0;
		res_value  = '0;
		res_offset = '0;
		res_status = anp_pkg::ST_OK;
		mac        = '0;

		if (first_char) begin
			ctl_nxt.negative   = 1'b0;
			ctl_nxt.digit_seen = 1'b0;
			ctl_nxt.base       = cfg_base;
			acc_w              = '0;
			pos_w              = '0;
			if (cfg_base == anp_pkg::BASE_ONE || cfg_base > anp_pkg::MAX_BASE) begin
				ctl_nxt.phase = anp_pkg::PH_DONE;
				emit          = 1'b1;
				res_status    = anp_pkg::ST_BAD_BASE;
			end else begin
				ctl_nxt.phase = anp_pkg::PH_LEAD;
			end
		end

		if (ctl_nxt.phase == anp_pkg::PH_LEAD) begin
			if (character inside {[anp_pkg::CH_TAB:anp_pkg::CH_CR], anp_pkg::CH_SPACE}) begin
				consume = 1'b1;
			end else if (character == anp_pkg::CH_PLUS || character == anp_pkg::CH_MINUS) begin
				ctl_nxt.negative = (character == anp_pkg::CH_MINUS);
				ctl_nxt.phase    = anp_pkg::PH_ZERO;
				consume          = 1'b1;
			end else begin
				ctl_nxt.phase = anp_pkg::PH_ZERO;
			end
		end

		if (ctl_nxt.phase == anp_pkg::PH_ZERO && !consume) begin
			if (character == anp_pkg::CH_ZERO) begin
				ctl_nxt.phase = anp_pkg::PH_PREFIX;
				consume       = 1'b1;
			end else begin
				if (ctl_nxt.base == anp_pkg::BASE_AUTO) begin
					ctl_nxt.base = anp_pkg::BASE_DEC;
				end
				ctl_nxt.phase = anp_pkg::PH_DIGITS;
			end
		end

		if (ctl_nxt.phase == anp_pkg::PH_PREFIX && !consume) begin
			if ((ctl_nxt.base == anp_pkg::BASE_AUTO || ctl_nxt.base == anp_pkg::BASE_HEX) &&
			    (character == anp_pkg::CH_LO_X || character == anp_pkg::CH_UP_X)) begin
				ctl_nxt.base  = anp_pkg::BASE_HEX;
				ctl_nxt.phase = anp_pkg::PH_DIGITS;
				consume       = 1'b1;
			end else begin
				ctl_nxt.digit_seen = 1'b1;
				if (ctl_nxt.base == anp_pkg::BASE_AUTO) begin
					ctl_nxt.base = anp_pkg::BASE_OCT;
				end
				ctl_nxt.phase = anp_pkg::PH_DIGITS;
			end
		end

		if (ctl_nxt.phase == anp_pkg::PH_DIGITS && !consume) begin
			if (dig < ctl_nxt.base) begin
				ctl_nxt.digit_seen = 1'b1;
				mac     = acc_w * ctl_nxt.base
				        + {{VALUE_BITS{1'b0}}, dig};
				acc_w   = mac[VALUE_BITS-1:0];
				consume = 1'b1;
			end else begin
				ctl_nxt.phase = anp_pkg::PH_DONE;
				emit          = 1'b1;
				res_offset    = ctl_nxt.digit_seen ? pos_w : '0;
				if (ctl_nxt.negative) begin
					if (!acc_w[VALUE_BITS-1]) begin
						res_value = '0 - acc_w;
					end else begin
						res_value  = '1;
						res_status = anp_pkg::ST_RANGE;
					end
				end else begin
					res_value = acc_w;
				end
			end
		end

		if (consume && pos_w != {OFFSET_BITS{1'b1}}) begin
			pos_w = pos_w + 1'b1;
		end
	end

	assign acc_nxt = acc_w;
	assign pos_nxt = pos_w;

endmodule
